// File: hdl/sitda_pkg.sv
package sitda_pkg;

	// default word width of the integer taken in
	localparam int DEFAULT_VALUE_WIDTH = 32;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// ascii codes, truncated to the six bits the text port carries
	localparam logic [5:0] CHAR_ZERO  = 6'd48;
	localparam logic [5:0] CHAR_MINUS = 6'd45;

	// bcd digit threshold for the add-3 correction and the correction itself
	localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
	localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

	// fixed-point log10(2) scaled by 4096, used to size the digit store
	localparam int LOG10_2_Q12 = 1233;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// decimal digits needed for any unsigned number of w bits
	function automatic int digit_count(input int w);
		return ((w * LOG10_2_Q12) >> 12) + 1;
	endfunction

endpackage

// File: hdl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
// Request channel: drive value and raise start; the request is taken at a
// rising edge where start is high and busy is low. busy rises only while the
// two-entry queue between the front and the converter is full.
// Result channel: one character per cycle-long pulse of char_strobe, most
// significant first: a leading '-' for negative values, then the digits with
// no leading zeros ('0' alone for zero). last_char marks the final character.
// The receiver cannot stall; characters are sent as they are produced.
// Steps per number: the back end takes it from the queue, runs the
// shift-and-add-3 binary to BCD conversion over the VALUE_WIDTH bits, sends
// the sign when negative, then walks each digit position of the BCD store
// (10 at 32 bits), dropping leading zeros silently. A new number is taken from
// the queue only once the converter is idle again.
// Reset (arst_n low, asynchronous) empties the queue, returns the converter
// to idle and clears char_strobe and last_char.
module signed_int_to_decimal_ascii #(
	parameter int VALUE_WIDTH = sitda_pkg::DEFAULT_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          char_strobe,
	output logic [5:0]                    text_char,
	output logic                          last_char
);
	import sitda_pkg::*;

	q_status_t            q_status;
	logic                 push;
	logic [VALUE_WIDTH:0] push_data;
	logic                 pop;
	logic [VALUE_WIDTH:0] pop_data;

	// sign split and request acceptance
	sitda_front #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.start     (start),
		.busy      (busy),
		.value     (value),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	sitda_queue #(
		.DATA_WIDTH (VALUE_WIDTH + 1),
		.DEPTH      (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_status  (q_status)
	);

	// bcd conversion and character emission
	sitda_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.pop_data    (pop_data),
		.pop         (pop),
		.char_strobe (char_strobe),
		.text_char   (text_char),
		.last_char   (last_char)
	);

endmodule

// File: hdl/sitda_front.sv
module sitda_front #(
	parameter int VALUE_WIDTH = sitda_pkg::DEFAULT_VALUE_WIDTH
) (
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  sitda_pkg::q_status_t          q_status,
	output logic                          push,
	output logic [VALUE_WIDTH:0]          push_data
);
	import sitda_pkg::*;

	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;

	// requests are held off only while the queue is full
	assign busy = q_status.full;
	assign push = start && !q_status.full;

	// sign split and unsigned magnitude; the most negative value wraps to 2^(w-1)
	assign neg       = value[VALUE_WIDTH-1];
	assign mag       = neg ? (~value + VALUE_WIDTH'(1)) : value;
	assign push_data = {neg, mag};

endmodule

// File: hdl/sitda_queue.sv
module sitda_queue #(
	parameter int DATA_WIDTH = sitda_pkg::DEFAULT_VALUE_WIDTH + 1,
	parameter int DEPTH      = sitda_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [DATA_WIDTH-1:0]  push_data,
	input  logic                   pop,
	output logic [DATA_WIDTH-1:0]  pop_data,
	output sitda_pkg::q_status_t   q_status
);
	import sitda_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] entries_q [DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [CW-1:0]         count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign pop_data       = entries_q[rd_ptr_q];
	assign q_status.full  = (count_q == CW'(DEPTH));
	assign q_status.empty = (count_q == '0);

endmodule

// File: hdl/sitda_back.sv
module sitda_back #(
	parameter int VALUE_WIDTH = sitda_pkg::DEFAULT_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sitda_pkg::q_status_t   q_status,
	input  logic [VALUE_WIDTH:0]   pop_data,
	output logic                   pop,
	output logic                   char_strobe,
	output logic [5:0]             text_char,
	output logic                   last_char
);
	import sitda_pkg::*;

	localparam int ND  = digit_count(VALUE_WIDTH);
	localparam int BW  = ND * 4;
	localparam int CW  = $clog2(VALUE_WIDTH);
	localparam int DCW = $clog2(ND + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DABBLE = 2'd1;
	localparam logic [1:0] ST_SIGN   = 2'd2;
	localparam logic [1:0] ST_DIGITS = 2'd3;

	logic [1:0]             state_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [BW-1:0]          bcd_q;
	logic [CW-1:0]          bit_cnt_q;
	logic [DCW-1:0]         dig_left_q;
	logic                   lead_q;
	logic                   strobe_q;
	logic [5:0]             char_q;
	logic                   last_q;

	logic [BW-1:0]          bcd_adj;
	logic [3:0]             top_digit;

	// add-3 correction on every digit before the shift
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= BCD_ADJ_LIMIT) ?
				bcd_q[i*4 +: 4] + BCD_ADJ_ADD : bcd_q[i*4 +: 4];
		end
	end

	assign top_digit = bcd_q[BW-1 -: 4];
	assign pop       = (state_q == ST_IDLE) && !q_status.empty;

	// sequencer: take a request, convert to bcd, then emit characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_status.empty) begin
						state_q <= ST_DABBLE;
					end
				end
				ST_DABBLE: begin
					if (bit_cnt_q == '0) begin
						state_q <= neg_q ? ST_SIGN : ST_DIGITS;
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= ST_DIGITS;
				end
				ST_DIGITS: begin
					if (dig_left_q == DCW'(1)) begin
						strobe_q <= 1'b1;
						last_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (!(lead_q && top_digit == 4'd0)) begin
						strobe_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				neg_q     <= pop_data[VALUE_WIDTH];
				mag_q     <= pop_data[VALUE_WIDTH-1:0];
				bcd_q     <= '0;
				bit_cnt_q <= CW'(VALUE_WIDTH - 1);
			end
			ST_DABBLE: begin
				bcd_q      <= {bcd_adj[BW-2:0], mag_q[VALUE_WIDTH-1]};
				mag_q      <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
				bit_cnt_q  <= bit_cnt_q - CW'(1);
				dig_left_q <= DCW'(ND);
				lead_q     <= 1'b1;
			end
			ST_SIGN: begin
				char_q <= CHAR_MINUS;
			end
			ST_DIGITS: begin
				// leading zeros are dropped without a character
				if (dig_left_q == DCW'(1) || !(lead_q && top_digit == 4'd0)) begin
					char_q <= CHAR_ZERO + {2'b00, top_digit};
					lead_q <= 1'b0;
				end
				bcd_q      <= {bcd_q[BW-5:0], 4'd0};
				dig_left_q <= dig_left_q - DCW'(1);
			end
			default: begin
				bcd_q <= '0;
			end
		endcase
	end

	assign char_strobe = strobe_q;
	assign text_char   = char_q;
	assign last_char   = last_q;

`ifndef SYNTHESIS
	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_q |-> strobe_q)
		else $error("last flag without character strobe");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> (char_q == CHAR_MINUS ||
			(char_q >= CHAR_ZERO && char_q <= CHAR_ZERO + 6'd9)))
		else $error("character outside minus and digits");

	a_quiet_in_dabble: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DABBLE) |=> !strobe_q)
		else $error("character emitted during conversion");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!q_status.empty && (!strobe_q || last_q)))
		else $error("new request taken before previous text finished");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import sitda_pkg::*;

	localparam int VW = DEFAULT_VALUE_WIDTH;
	localparam int MAX_DIGITS = 21;
	localparam int N_DIRECTED = 22;
	localparam int N_RANDOM = 248;

	// one character of decimal text as it should leave the block
	typedef struct {
		logic [5:0] ch;
		logic       last;
	} text_char_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [VW-1:0] value;
	logic                 char_strobe;
	logic [5:0]           text_char;
	logic                 last_char;

	text_char_t pending_chars[$];
	int         failures = 0;

	// directed requests; a non-empty text is the typed-in expectation
	logic signed [VW-1:0] directed_values[N_DIRECTED] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd9, -32'sd10, 32'sd99,
		32'sd100, 32'sd2147483647, -32'sd2147483647, 32'h8000_0000,
		32'sd1000000000, -32'sd1000000000, 32'sd999999999, 32'sd123456789,
		-32'sd987654321, 32'h4000_0000, 32'hC000_0000, 32'h5555_5555,
		32'hAAAA_AAAA, 32'sd1000
	};
	string directed_texts[N_DIRECTED] = '{
		"0", "1", "-1", "9", "10", "", "", "",
		"", "2147483647", "", "-2147483648",
		"", "", "", "",
		"", "", "", "",
		"", ""
	};

	signed_int_to_decimal_ascii #(
		.VALUE_WIDTH(VW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.char_strobe(char_strobe),
		.text_char(text_char),
		.last_char(last_char)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// decimal text of a signed word: sign, then digits of the unsigned magnitude
	function automatic void predict_text(logic [VW-1:0] v);
		logic [VW-1:0] mag;
		logic [3:0]    digits[MAX_DIGITS];
		int            nd;
		text_char_t    c;
		mag = v[VW-1] ? (~v + 1'b1) : v;
		nd = 0;
		do begin
			digits[nd] = 4'(mag % 10);
			nd++;
			mag = mag / 10;
		end while (mag != 0 && nd < MAX_DIGITS);
		if (v[VW-1]) begin
			c.ch = CHAR_MINUS;
			c.last = 1'b0;
			pending_chars.push_back(c);
		end
		for (int k = nd - 1; k >= 0; k--) begin
			c.ch = CHAR_ZERO + 6'(digits[k]);
			c.last = (k == 0);
			pending_chars.push_back(c);
		end
	endfunction

	// typed-in text, the final character flagged
	function automatic void expect_typed(string s);
		text_char_t c;
		for (int i = 0; i < s.len(); i++) begin
			c.ch = 6'(s[i]);
			c.last = (i == s.len() - 1);
			pending_chars.push_back(c);
		end
	endfunction

	// hold a request until taken; called at a falling edge, returns at one
	task automatic send_request(logic signed [VW-1:0] v, int gap, string text);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		value = v;
		start = 1'b1;
		do @(posedge clk); while (busy);
		if (text.len() != 0)
			expect_typed(text);
		else
			predict_text(v);
		@(negedge clk);
	endtask

	// random word with weight on every digit count and on the extremes
	function automatic logic signed [VW-1:0] random_value();
		logic [VW-1:0] v;
		longint        span;
		int            d;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: begin
				d = $urandom_range(1, 10);
				span = 1;
				repeat (d) span = span * 10;
				if (span > 64'd2147483648)
					span = 64'd2147483648;
				v = VW'($urandom % span);
				if ($urandom_range(0, 1))
					v = ~v + 1'b1;
			end
			2: begin
				d = $urandom_range(0, 9);
				span = 1;
				repeat (d) span = span * 10;
				v = VW'(span) + VW'($urandom_range(0, 2)) - 1'b1;
				if ($urandom_range(0, 1))
					v = ~v + 1'b1;
			end
			default: begin
				if ($urandom_range(0, 1))
					v = 32'h8000_0000 + VW'($urandom_range(0, 15));
				else
					v = 32'h7FFF_FFFF - VW'($urandom_range(0, 15));
			end
		endcase
		return v;
	endfunction

	// result checking against the oldest expectation
	always @(posedge clk) begin
		text_char_t e;
		if (arst_n && char_strobe) begin
			if (pending_chars.size() == 0) begin
				$error("character with none expected: text_char %0d last_char %0d",
					text_char, last_char);
				failures++;
			end else begin
				e = pending_chars.pop_front();
				if (text_char !== e.ch) begin
					$error("text_char: expected %0d, got %0d", e.ch, text_char);
					failures++;
				end
				if (last_char !== e.last) begin
					$error("last_char: expected %0d, got %0d", e.last, last_char);
					failures++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int burst_left;
		int gap;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed requests, random spacing
		for (int i = 0; i < N_DIRECTED; i++)
			send_request(directed_values[i], $urandom_range(0, 12), directed_texts[i]);

		// random requests, with stretches sent back to back
		burst_left = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (burst_left == 0 && $urandom_range(0, 15) == 0)
				burst_left = $urandom_range(8, 24);
			if (burst_left > 0) begin
				gap = 0;
				burst_left--;
			end else begin
				gap = $urandom_range(0, 12);
			end
			send_request(random_value(), gap, "");
		end
		start = 1'b0;

		// drain, then leave room for any stray characters
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// run limit
	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
hdl/sitda_pkg.sv
hdl/sitda_front.sv
hdl/sitda_queue.sv
hdl/sitda_back.sv
hdl/signed_int_to_decimal_ascii.sv
tb/testbench.sv
